[rtl/core/ldrt_pkg.sv]
// ----------------------------------------------------------------------------
// ldrt_pkg: shared types and constants for the longest distinct run tracker
// Request payload types for both channels and default sizing.
// ----------------------------------------------------------------------------
package ldrt_pkg;

  localparam int DATA_W      = 32;
  localparam int LEN_W       = 7;
  localparam int MAX_WIN_DEF = 64;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     first;
  } in_t;

  typedef struct packed {
    logic [LEN_W-1:0] run_len;
    logic [LEN_W-1:0] best_len;
    logic             overflow;
  } out_t;

endpackage

[rtl/core/longest_distinct_run_tracker.sv]
// ----------------------------------------------------------------------------
// longest_distinct_run_tracker: longest run of distinct values in a stream
// Tracks the current all-distinct window and the longest one seen.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_data) takes one signed 32-bit value
//   per request; in_data.first starts a new sequence (window, best length
//   and overflow cleared before the value is taken in).
//   Output channel (out_valid/out_stall/out_data) returns one result per
//   request: current run length, best length and the sticky overflow flag.
//   A request passes through two registers before out_valid rises: the input
//   register, then the window match and state update land in the output
//   register.
//   Throughput is one request per cycle while out_stall does not hold a
//   waiting result; the window is a circular register store compared against
//   the value in parallel, so each item's match and state update are combinational.
//   While out_stall holds a waiting result, one more request is taken into
//   the input register, after which in_stall rises until the result drains.
//   Synchronous reset empties the window and clears best length, overflow
//   and both valid flags; slot contents are left as they are.
// ----------------------------------------------------------------------------
module longest_distinct_run_tracker #(
  parameter int MaxWin = ldrt_pkg::MAX_WIN_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  ldrt_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output ldrt_pkg::out_t out_data
);

  localparam int IdxW = $clog2(MaxWin);
  localparam int LenW = $clog2(MaxWin + 1);

  function automatic logic [IdxW-1:0] wrap_inc(input logic [IdxW-1:0] p);
    logic [IdxW-1:0] r;
    if (p == IdxW'(MaxWin - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  logic           s1_valid_r, s1_valid_nxt;
  ldrt_pkg::in_t  s1_r;
  logic           out_valid_r, out_valid_nxt;
  ldrt_pkg::out_t out_r, out_nxt;
  logic [IdxW-1:0] head_r, head_nxt;
  logic [IdxW-1:0] tail_r, tail_nxt;
  logic [LenW-1:0] len_r, len_nxt;
  logic [LenW-1:0] best_r, best_nxt;
  logic            ovf_r, ovf_nxt;

  logic            accept;
  logic            advance;
  logic [IdxW-1:0] head_eff;
  logic [LenW-1:0] len_eff;
  logic [LenW-1:0] best_eff;
  logic            ovf_eff;
  logic            hit;
  logic [IdxW-1:0] hit_off;
  logic [IdxW:0]   hit_next;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  // start flag: empty window at the tail
  assign head_eff = s1_r.first ? tail_r : head_r;
  assign len_eff  = s1_r.first ? '0 : len_r;
  assign best_eff = s1_r.first ? '0 : best_r;
  assign ovf_eff  = s1_r.first ? 1'b0 : ovf_r;

  ldrt_window #(
    .MaxWin (MaxWin)
  ) u_window (
    .clk     (clk),
    .wr_en   (advance),
    .wr_idx  (tail_r),
    .wr_data (s1_r.value),
    .head    (head_eff),
    .len     (len_eff),
    .key     (s1_r.value),
    .hit     (hit),
    .hit_off (hit_off)
  );

  always_comb begin
    hit_next = {1'b0, head_eff} + {1'b0, hit_off} + (IdxW+1)'(1);
    if (hit_next >= (IdxW+1)'(MaxWin)) begin
      hit_next = hit_next - (IdxW+1)'(MaxWin);
    end

    head_nxt = head_eff;
    len_nxt  = len_eff + 1'b1;
    ovf_nxt  = ovf_eff;
    if (hit) begin
      // drop everything up to and including the earlier copy
      head_nxt = hit_next[IdxW-1:0];
      len_nxt  = len_eff - LenW'(hit_off);
    end else if (len_eff == LenW'(MaxWin)) begin
      // full: evict oldest, tail overwrites it
      head_nxt = wrap_inc(head_eff);
      len_nxt  = len_eff;
      ovf_nxt  = 1'b1;
    end
    tail_nxt = wrap_inc(tail_r);
    best_nxt = (len_nxt > best_eff) ? len_nxt : best_eff;

    out_nxt.run_len  = ldrt_pkg::LEN_W'(len_nxt);
    out_nxt.best_len = ldrt_pkg::LEN_W'(best_nxt);
    out_nxt.overflow = ovf_nxt;
  end

  assign s1_valid_nxt  = accept || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      len_r       <= '0;
      best_r      <= '0;
      ovf_r       <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        head_r <= head_nxt;
        tail_r <= tail_nxt;
        len_r  <= len_nxt;
        best_r <= best_nxt;
        ovf_r  <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= in_data;
    end
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LenW'(MaxWin))
    else $error("window length above capacity");

  a_best_ge_len: assert property (@(posedge clk) disable iff (!rst_n)
    best_r >= len_r)
    else $error("best length below current length");

  a_first_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_r.first |-> !hit)
    else $error("match found in a cleared window");

  a_hit_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && hit |-> LenW'(hit_off) < len_eff)
    else $error("match offset outside window");

  a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed request produced no result");
`endif

endmodule

[rtl/core/ldrt_window.sv]
// ----------------------------------------------------------------------------
// ldrt_window: circular window store with parallel match
// Slots are written at the tail; every slot inside [head, head+len) is
// compared with the key, and the hit's offset from head is returned.
// ----------------------------------------------------------------------------
module ldrt_window #(
  parameter int MaxWin = ldrt_pkg::MAX_WIN_DEF,
  localparam int IdxW  = $clog2(MaxWin),
  localparam int LenW  = $clog2(MaxWin + 1)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [IdxW-1:0]             wr_idx,
  input  logic [ldrt_pkg::DATA_W-1:0] wr_data,
  input  logic [IdxW-1:0]             head,
  input  logic [LenW-1:0]             len,
  input  logic [ldrt_pkg::DATA_W-1:0] key,
  output logic                        hit,
  output logic [IdxW-1:0]             hit_off
);

  logic [ldrt_pkg::DATA_W-1:0] slot_r [MaxWin];
  logic [IdxW-1:0]             off    [MaxWin];
  logic [MaxWin-1:0]           match;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_idx] <= wr_data;
    end
  end

  // position of each slot relative to the window start
  always_comb begin
    logic [IdxW:0] diff;
    for (int s = 0; s < MaxWin; s++) begin
      diff = (IdxW+1)'(s) - {1'b0, head};
      if (head > IdxW'(s)) begin
        diff = diff + (IdxW+1)'(MaxWin);
      end
      off[s]   = diff[IdxW-1:0];
      match[s] = (LenW'(off[s]) < len) && (slot_r[s] == key);
    end
  end

  // at most one slot matches, so an OR merge picks its offset
  always_comb begin
    hit_off = '0;
    for (int s = 0; s < MaxWin; s++) begin
      hit_off = hit_off | (match[s] ? off[s] : '0);
    end
  end

  assign hit = |match;

endmodule

[tb/longest_distinct_run_tracker_tb.sv]
// ----------------------------------------------------------------------------
// longest_distinct_run_tracker_tb: self-checking bench for the run tracker
// Drives value streams with random gaps and output stalls. A scoreboard keeps
// its own distinct window and checks each result's run length, best length
// and overflow flag against it, in order.
// ----------------------------------------------------------------------------
module longest_distinct_run_tracker_tb;

  localparam int WinDepth = ldrt_pkg::MAX_WIN_DEF;

  class DistinctRunScoreboard;
    logic [ldrt_pkg::DATA_W-1:0] window_q[$];
    int                          best_len;
    bit                          overflow_seen;
    ldrt_pkg::out_t              awaited_q[$];
    int                          mismatches;

    function int pending();
      return awaited_q.size();
    endfunction

    function void absorb_request(ldrt_pkg::in_t req);
      int             hit;
      ldrt_pkg::out_t exp_res;
      if (req.first) begin
        window_q.delete();
        best_len      = 0;
        overflow_seen = 1'b0;
      end
      hit = -1;
      foreach (window_q[i]) begin
        if (window_q[i] == req.value) hit = i;
      end
      if (hit >= 0) begin
        repeat (hit + 1) void'(window_q.pop_front());
      end else if (window_q.size() >= WinDepth) begin
        void'(window_q.pop_front());
        overflow_seen = 1'b1;
      end
      window_q.push_back(req.value);
      if (window_q.size() > best_len) best_len = window_q.size();
      exp_res.run_len  = ldrt_pkg::LEN_W'(window_q.size());
      exp_res.best_len = ldrt_pkg::LEN_W'(best_len);
      exp_res.overflow = overflow_seen;
      awaited_q.push_back(exp_res);
    endfunction

    function void check_result(ldrt_pkg::out_t got);
      ldrt_pkg::out_t exp_res;
      if (awaited_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: run_len=%0d best_len=%0d overflow=%0d",
                   got.run_len, got.best_len, got.overflow);
        return;
      end
      exp_res = awaited_q.pop_front();
      if (got.run_len !== exp_res.run_len || got.best_len !== exp_res.best_len ||
          got.overflow !== exp_res.overflow) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected run_len=%0d best_len=%0d overflow=%0d, got %0d %0d %0d",
                   exp_res.run_len, exp_res.best_len, exp_res.overflow,
                   got.run_len, got.best_len, got.overflow);
      end
    endfunction
  endclass

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_stall;
  ldrt_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  ldrt_pkg::out_t out_data;

  DistinctRunScoreboard sb;
  int                   requests_sent;
  bit                   rx_pause_on;

  longest_distinct_run_tracker dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever begin
      #6 clk = ~clk;
    end
  end

  initial begin
    #(12 * 400000);
    $display("longest_distinct_run_tracker_tb failed");
    $finish;
  end

  task automatic send_request(input ldrt_pkg::in_t req, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    sb.absorb_request(req);
    requests_sent++;
  endtask

  task automatic send_value(input logic [31:0] v, input bit first);
    ldrt_pkg::in_t req;
    req.value = v;
    req.first = first;
    send_request(req, $urandom_range(0, 5));
  endtask

  // hold the input off until every outstanding request has come back
  task automatic drain_wait();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_segment();
    int            mode;
    int            len;
    int            pool;
    bit            tx_idle;
    bit            lead_first;
    logic [31:0]   base;
    ldrt_pkg::in_t req;
    mode        = $urandom_range(0, 9);
    base        = $urandom();
    tx_idle     = $urandom_range(0, 3) != 0;
    rx_pause_on = $urandom_range(0, 3) != 0;
    lead_first  = $urandom_range(0, 3) != 0;
    pool        = $urandom_range(2, 80);
    if (mode <= 5) len = $urandom_range(5, 60);
    else if (mode <= 7) len = $urandom_range(60, 90);
    else len = $urandom_range(5, 30);
    for (int k = 0; k < len; k++) begin
      if (mode <= 5) begin
        req.value = base + $urandom_range(0, pool - 1);
        req.first = (k == 0) && lead_first;
      end else if (mode <= 7) begin
        // long distinct ramp, now and then a repeat of an earlier value
        if (k > 0 && $urandom_range(0, 19) == 0) req.value = base + $urandom_range(0, k - 1);
        else req.value = base + k;
        req.first = (k == 0) && lead_first;
      end else begin
        req.value = $urandom();
        req.first = $urandom_range(0, 7) == 0;
      end
      send_request(req, tx_idle ? $urandom_range(0, 5) : 0);
    end
  endtask

  initial begin
    forever begin
      int hold;
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        sb.check_result(out_data);
        hold = rx_pause_on ? $urandom_range(0, 5) : 0;
        if (hold > 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin
    logic [31:0] ramp_base;
    sb            = new;
    requests_sent = 0;
    rx_pause_on   = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // sequence that began at reset, then value extremes and repeats
    send_value(32'h0000_0000, 1'b0);
    send_value(32'h0000_0000, 1'b0);
    send_value(32'h8000_0000, 1'b1);
    send_value(32'h7FFF_FFFF, 1'b0);
    send_value(32'hFFFF_FFFF, 1'b0);
    send_value(32'h0000_0000, 1'b0);
    send_value(32'h8000_0000, 1'b0);
    send_value(32'h7FFF_FFFE, 1'b0);
    send_value(32'h0000_0000, 1'b0);
    send_value(32'h0000_0001, 1'b0);
    send_value(32'h0000_0005, 1'b1);
    send_value(32'h0000_0005, 1'b1);
    send_value(32'h0000_0005, 1'b0);
    send_value(32'hFFFF_FFFE, 1'b0);
    send_value(32'h0000_0005, 1'b0);
    drain_wait();

    // fill past the window, repeat the newest value and the oldest, then restart
    ramp_base = $urandom();
    for (int k = 0; k < WinDepth + 6; k++) send_value(ramp_base + k, k == 0);
    send_value(ramp_base + WinDepth + 5, 1'b0);
    send_value(ramp_base, 1'b0);
    send_value(ramp_base, 1'b1);

    while (requests_sent < 950) begin
      run_segment();
      if ($urandom_range(0, 7) == 0) drain_wait();
    end
    in_valid <= 1'b0;
    rx_pause_on = 1'b1;

    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("longest_distinct_run_tracker_tb passed");
    end else begin
      $display("longest_distinct_run_tracker_tb failed");
    end
    $finish;
  end

endmodule
